// ===== hdl/tree_independence_poly_qform_unit_assert.svh =====
// assertion macros for the tree independence unit
`ifndef TREE_INDEPENDENCE_POLY_QFORM_UNIT_ASSERT_SVH
`define TREE_INDEPENDENCE_POLY_QFORM_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define TIP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tip assertion failed");

// next-cycle implication
`define TIP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tip assertion failed");

`endif

// ===== hdl/tip_pkg.sv =====
`timescale 1ns / 1ps
package tip_pkg;
	localparam int MaxCore = 16;
	localparam int MaxOrder = 31;
	localparam int NCoef = 9;
	localparam int AccW = 24;
	localparam int OutW = 23;
	localparam int FormW = 55;
	localparam int VidW = $clog2(MaxCore);
	localparam int LeafW = 5;
	localparam int CoefIdxW = 4;

	typedef logic [AccW-1:0] acc_t;
endpackage

// ===== hdl/tree_independence_poly_qform_unit.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_stall   | vertex_id parent_id leaf_count
// out     | output    | out_valid/out_stall | coef0..coef8 form_value
// non-root beat, from accept to accept: two row loads, the excluded row times (1 + x)
// once per leaf, two parent folds (row load, multiply, write back), then a slot clear
// root beat: the row loads and leaves, then the quadratic form runs before the emit
// reset starts a clearing pass of the accumulator memory; no beat is taken then
// in_stall is high while a beat is in work; a root holds at emit while a result is stalled
`include "tree_independence_poly_qform_unit_assert.svh"
module tree_independence_poly_qform_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [tip_pkg::VidW-1:0]         vertex_id,
	input  logic [tip_pkg::VidW-1:0]         parent_id,
	input  logic [tip_pkg::LeafW-1:0]        leaf_count,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [tip_pkg::OutW-1:0]         coef0,
	output logic [tip_pkg::OutW-1:0]         coef1,
	output logic [tip_pkg::OutW-1:0]         coef2,
	output logic [tip_pkg::OutW-1:0]         coef3,
	output logic [tip_pkg::OutW-1:0]         coef4,
	output logic [tip_pkg::OutW-1:0]         coef5,
	output logic [tip_pkg::OutW-1:0]         coef6,
	output logic [tip_pkg::OutW-1:0]         coef7,
	output logic [tip_pkg::OutW-1:0]         coef8,
	output logic signed [tip_pkg::FormW-1:0] form_value
);
	localparam int N = tip_pkg::NCoef;
	localparam int KW = tip_pkg::CoefIdxW;
	localparam int VW = tip_pkg::VidW;
	localparam int OW = tip_pkg::OutW;
	localparam int FW = tip_pkg::FormW;
	localparam int AW = 1 + VW + KW; // {sel, vertex, coef}
	localparam logic [KW-1:0] KOne = KW'(1);
	localparam logic [KW-1:0] KLast = KW'(N - 1);
	localparam logic [KW-1:0] KLoadEnd = KW'(N);
	localparam logic [3:0] FormTerms = 4'd12;

	typedef enum logic [9:0] {
		S_CLR  = 10'b0000000001,
		S_IDLE = 10'b0000000010,
		S_LDV  = 10'b0000000100,
		S_LEAF = 10'b0000001000,
		S_LDP  = 10'b0000010000,
		S_MUL  = 10'b0000100000,
		S_WB   = 10'b0001000000,
		S_FORM = 10'b0010000000,
		S_EMIT = 10'b0100000000,
		S_CLRV = 10'b1000000000
	} state_t;

	state_t st_q;
	logic sel_q;
	logic [KW-1:0] k_q, i_q, j_q;
	logic [VW:0] cnt_q;
	logic [VW-1:0] v_q, p_q;
	logic [tip_pkg::LeafW-1:0] lc_q;
	tip_pkg::acc_t exc_q [0:N-1];
	tip_pkg::acc_t inc_q [0:N-1];
	tip_pkg::acc_t opa_q [0:N-1];
	tip_pkg::acc_t t_q [0:N-1];
	logic [OW-1:0] c_q [0:N-1];
	tip_pkg::acc_t mem [0:(1<<AW)-1];
	tip_pkg::acc_t rd_s1;
	logic [AW-1:0] ra, wa;
	logic we;
	tip_pkg::acc_t wd;
	logic [3:0] fstep_q;
	logic [2*OW-1:0] prod_s1;
	logic signed [8:0] fk_s1;
	logic [FW-1:0] facc_q;
	logic signed [FW:0] fterm;
	logic emit_go;
	logic [KW-1:0] tk;
	tip_pkg::acc_t bop, mprod;
	logic [OW-1:0] fa, fb;
	logic signed [8:0] fk;

	// mem read/write; the read data is registered
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_s1 <= mem[ra];
	end

	assign in_stall = (st_q != S_IDLE);
	assign emit_go = (st_q == S_EMIT) && (!out_valid || !out_stall);

	always_comb begin
		ra = '0;
		unique case (st_q)
			S_LDV: ra = {sel_q, v_q, k_q};
			S_LDP: ra = {sel_q, p_q, k_q};
			default: ra = '0;
		endcase
	end

	always_comb begin
		we = 1'b0; wa = '0; wd = '0;
		unique case (st_q)
			S_CLR: begin
				we = 1'b1;
				wa = {cnt_q, k_q};
				wd = cnt_q[VW] ? tip_pkg::acc_t'(k_q == KOne) : tip_pkg::acc_t'(k_q == '0);
			end
			S_WB: begin
				we = 1'b1;
				wa = {sel_q, p_q, k_q};
				wd = t_q[k_q];
			end
			S_CLRV: begin
				we = 1'b1;
				wa = {sel_q, v_q, k_q};
				wd = sel_q ? tip_pkg::acc_t'(k_q == KOne) : tip_pkg::acc_t'(k_q == '0);
			end
			default: ;
		endcase
	end

	// parent excluded takes exc + inc, parent included takes exc
	assign tk = i_q + j_q;
	assign bop = sel_q ? exc_q[j_q] : exc_q[j_q] + inc_q[j_q];
	assign mprod = opa_q[i_q] * bop;

	// quadratic form term select
	always_comb begin
		fa = c_q[3]; fb = c_q[3]; fk = 9'sd8;
		case (fstep_q)
			4'd0:  begin fa = c_q[3]; fb = c_q[3]; fk = 9'sd8;    end
			4'd1:  begin fa = c_q[3]; fb = c_q[4]; fk = 9'sd24;   end
			4'd2:  begin fa = c_q[3]; fb = c_q[5]; fk = -9'sd64;  end
			4'd3:  begin fa = c_q[3]; fb = c_q[6]; fk = -9'sd106; end
			4'd4:  begin fa = c_q[3]; fb = c_q[7]; fk = -9'sd51;  end
			4'd5:  begin fa = c_q[3]; fb = c_q[8]; fk = -9'sd8;   end
			4'd6:  begin fa = c_q[4]; fb = c_q[4]; fk = 9'sd80;   end
			4'd7:  begin fa = c_q[4]; fb = c_q[5]; fk = 9'sd90;   end
			4'd8:  begin fa = c_q[4]; fb = c_q[6]; fk = -9'sd12;  end
			4'd9:  begin fa = c_q[4]; fb = c_q[7]; fk = -9'sd10;  end
			4'd10: begin fa = c_q[5]; fb = c_q[5]; fk = 9'sd39;   end
			4'd11: begin fa = c_q[5]; fb = c_q[6]; fk = 9'sd10;   end
			default: begin fa = '0; fb = '0; fk = '0; end
		endcase
	end

	assign fterm = $signed({1'b0, prod_s1}) * fk_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			sel_q <= 1'b0; k_q <= '0; i_q <= '0; j_q <= '0; cnt_q <= '0;
			v_q <= '0; p_q <= '0; lc_q <= '0;
			fstep_q <= '0; prod_s1 <= '0; fk_s1 <= '0; facc_q <= '0;
			out_valid <= 1'b0; form_value <= '0;
			coef0 <= '0; coef1 <= '0; coef2 <= '0; coef3 <= '0; coef4 <= '0;
			coef5 <= '0; coef6 <= '0; coef7 <= '0; coef8 <= '0;
			for (int k = 0; k < N; k++) begin
				exc_q[k] <= '0; inc_q[k] <= '0; opa_q[k] <= '0; t_q[k] <= '0; c_q[k] <= '0;
			end
		end else begin
			if (emit_go) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			unique case (st_q)
				S_CLR: begin
					if (k_q == KLast) begin
						k_q <= '0;
						cnt_q <= cnt_q + (VW+1)'(1);
						if (cnt_q == '1) st_q <= S_IDLE;
					end else k_q <= k_q + KOne;
				end
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						v_q <= vertex_id; p_q <= parent_id; lc_q <= leaf_count;
						sel_q <= 1'b0; k_q <= '0;
						st_q <= S_LDV;
					end
				end
				// excluded row of v, then its included row
				S_LDV: begin
					if (k_q != '0) begin
						if (sel_q) inc_q[k_q - KOne] <= rd_s1;
						else exc_q[k_q - KOne] <= rd_s1;
					end
					if (k_q == KLoadEnd) begin
						k_q <= '0;
						if (sel_q) begin sel_q <= 1'b0; st_q <= S_LEAF; end
						else sel_q <= 1'b1;
					end else k_q <= k_q + KOne;
				end
				// each leaf multiplies the excluded row by (1 + x)
				S_LEAF: begin
					if (lc_q != '0) begin
						for (int k = 1; k < N; k++) exc_q[k] <= exc_q[k] + exc_q[k-1];
						lc_q <= lc_q - tip_pkg::LeafW'(1);
					end else if (v_q == '0) begin
						for (int k = 0; k < N; k++) c_q[k] <= OW'(exc_q[k] + inc_q[k]);
						fstep_q <= '0; facc_q <= '0;
						st_q <= S_FORM;
					end else begin
						sel_q <= 1'b0; k_q <= '0;
						st_q <= S_LDP;
					end
				end
				S_LDP: begin
					if (k_q != '0) opa_q[k_q - KOne] <= rd_s1;
					if (k_q == KLoadEnd) begin
						k_q <= '0; i_q <= '0; j_q <= '0;
						for (int k = 0; k < N; k++) t_q[k] <= '0;
						st_q <= S_MUL;
					end else k_q <= k_q + KOne;
				end
				S_MUL: begin
					t_q[tk] <= t_q[tk] + mprod;
					if (tk == KLast) begin
						j_q <= '0;
						if (i_q == KLast) begin i_q <= '0; k_q <= '0; st_q <= S_WB; end
						else i_q <= i_q + KOne;
					end else j_q <= j_q + KOne;
				end
				S_WB: begin
					if (k_q == KLast) begin
						k_q <= '0;
						if (sel_q) begin sel_q <= 1'b0; st_q <= S_CLRV; end
						else begin sel_q <= 1'b1; st_q <= S_LDP; end
					end else k_q <= k_q + KOne;
				end
				// one product a cycle, accumulated in the next cycle
				S_FORM: begin
					if (fstep_q != FormTerms) begin
						prod_s1 <= fa * fb;
						fk_s1 <= fk;
						fstep_q <= fstep_q + 4'd1;
					end
					if (fstep_q != '0) facc_q <= facc_q + fterm[FW-1:0];
					if (fstep_q == FormTerms) st_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						form_value <= $signed(facc_q);
						coef0 <= c_q[0]; coef1 <= c_q[1]; coef2 <= c_q[2];
						coef3 <= c_q[3]; coef4 <= c_q[4]; coef5 <= c_q[5];
						coef6 <= c_q[6]; coef7 <= c_q[7]; coef8 <= c_q[8];
						sel_q <= 1'b0; k_q <= '0;
						st_q <= S_CLRV;
					end
				end
				S_CLRV: begin
					if (k_q == KLast) begin
						k_q <= '0;
						if (sel_q) begin sel_q <= 1'b0; st_q <= S_IDLE; end
						else sel_q <= 1'b1;
					end else k_q <= k_q + KOne;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`TIP_ASSERT_IMPL(a_stall_busy, st_q != S_IDLE, in_stall)
	`TIP_ASSERT_NEXT(a_emit_valid, emit_go, out_valid)
	`TIP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(form_value))
	`TIP_ASSERT_IMPL(a_no_write_idle, st_q == S_IDLE, !we)
endmodule
